[rtl/core/lzwve_pkg.sv]
// ----------------------------------------------------------------------------
// lzwve_pkg
// Shared types and constants of the variable width LZW encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwve_pkg;

    localparam int MAX_CODE_BITS   = 12;
    localparam int HASH_BITS       = 13;
    localparam int FIRST_FREE_CODE = 256;
    localparam int START_WIDTH     = 9;
    localparam int OUT_CELLS       = 4;
    localparam int CNT_W           = $clog2(OUT_CELLS + 1);

    typedef logic [MAX_CODE_BITS-1:0] t_code;
    typedef logic [MAX_CODE_BITS:0]   t_next_code;
    typedef logic [3:0]               t_width;
    typedef logic [HASH_BITS-1:0]     t_slot_addr;

    typedef struct packed {
        logic   last;
        t_width width;
        t_code  code;
    } t_res;

    typedef struct packed {
        logic       valid;
        t_code      pfx;
        logic [7:0] byt;
        t_code      code;
    } t_slot;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

[rtl/core/lzwve_dict.sv]
// ----------------------------------------------------------------------------
// lzwve_dict
// Hashed dictionary memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwve_dict (
    input  wire                     i_clk,
    input  wire                     i_rd_en,
    input  wire lzwve_pkg::t_slot_addr i_rd_addr,
    output lzwve_pkg::t_slot        o_rd_data,
    input  wire                     i_wr_en,
    input  wire lzwve_pkg::t_slot_addr i_wr_addr,
    input  wire lzwve_pkg::t_slot   i_wr_data
);
    import lzwve_pkg::*;

    t_slot r_mem [0:(1 << HASH_BITS)-1];
    t_slot r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

[rtl/core/lzwve_cell.sv]
// ----------------------------------------------------------------------------
// lzwve_cell
// One cell of the output chain: holds a code and moves it toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwve_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  wire                  i_load,
    input  wire lzwve_pkg::t_res i_load_data,
    input  wire                  i_up_valid,
    input  wire lzwve_pkg::t_res i_up_data,
    output logic                 o_valid,
    output lzwve_pkg::t_res      o_data
);
    import lzwve_pkg::*;

    logic r_valid, n_valid;
    t_res r_data, n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_shift) begin
            n_valid = i_up_valid;
            n_data  = i_up_data;
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_data  = i_load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[rtl/core/lzw_variable_width_encoder.sv]
// ----------------------------------------------------------------------------
// lzw_variable_width_encoder
// LZW encoder with growing code width (9 up to 12 bits), no clear/end codes.
//
// Input stream: one raw byte per item in s_axis_tdata, s_axis_tlast marks the
// last byte of a stream. Output stream: one code per item, m_axis_tdata holds
// the code and its width, m_axis_tlast marks the final code of a stream.
// An item passes through ST_IDLE, ST_CHECK and ST_FIN (ST_IDLE and ST_FIN for
// the first byte of a stream); ST_CHECK repeats for each further hash probe of
// the registered dictionary read port, one probe per cycle. A code that is
// found is registered in a cell of the output chain before it reaches
// m_axis_tdata. After reset, and after every stream end, a clearing pass over
// all 8192 slots empties the dictionary; no byte is taken meanwhile.
// Results wait in a chain of four cells; a new byte is taken while up to two
// codes still wait, so a stalled receiver holds the input only once the
// chain is that full. Nothing is dropped while m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_variable_width_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // code_value[11:0], code_width[15:12]
    output logic        m_axis_tlast    // last_code
);
    import lzwve_pkg::*;

    t_state     r_state, n_state;
    t_code      r_prefix, n_prefix;
    logic       r_pvalid, n_pvalid;
    t_next_code r_nfc, n_nfc;
    t_width     r_width, n_width;
    logic [7:0] r_byte, n_byte;
    logic       r_end, n_end;
    t_slot_addr r_addr, n_addr;
    t_slot_addr r_clr, n_clr;

    logic       rd_en, wr_en;
    t_slot_addr rd_addr, wr_addr;
    t_slot      rd_data, wr_data;

    logic       push;
    t_res       push_data;
    logic       pop;
    logic [CNT_W-1:0] cnt, pos;
    logic       accept;
    t_slot_addr key;
    t_next_code nfc_inc;

    logic cell_valid [OUT_CELLS];
    t_res cell_data  [OUT_CELLS];

    lzwve_dict u_dict (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        cnt = '0;
        for (int i = 0; i < OUT_CELLS; i++) begin
            cnt = cnt + CNT_W'(cell_valid[i]);
        end
    end

    assign m_axis_tvalid = cell_valid[0];
    assign m_axis_tdata  = {cell_data[0].width, cell_data[0].code};
    assign m_axis_tlast  = cell_data[0].last;
    assign pop           = cell_valid[0] && m_axis_tready;
    assign pos           = cnt - CNT_W'(pop);

    for (genvar g = 0; g < OUT_CELLS; g++) begin : g_cell
        logic up_valid;
        t_res up_data;
        if (g == OUT_CELLS - 1) begin : g_tail
            assign up_valid = 1'b0;
            assign up_data  = '0;
        end else begin : g_mid
            assign up_valid = cell_valid[g+1];
            assign up_data  = cell_data[g+1];
        end
        lzwve_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (pop),
            .i_load      (push && (pos == CNT_W'(g))),
            .i_load_data (push_data),
            .i_up_valid  (up_valid),
            .i_up_data   (up_data),
            .o_valid     (cell_valid[g]),
            .o_data      (cell_data[g])
        );
    end

    assign s_axis_tready = (r_state == ST_IDLE) && (cnt <= CNT_W'(OUT_CELLS - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign key           = {r_prefix[HASH_BITS-9:0], s_axis_tdata};
    assign nfc_inc       = r_nfc + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_prefix  = r_prefix;
        n_pvalid  = r_pvalid;
        n_nfc     = r_nfc;
        n_width   = r_width;
        n_byte    = r_byte;
        n_end     = r_end;
        n_addr    = r_addr;
        n_clr     = r_clr;
        rd_en     = 1'b0;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_addr   = r_addr;
        wr_data   = '0;
        push      = 1'b0;
        push_data = '0;

        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_byte = s_axis_tdata;
                    n_end  = s_axis_tlast;
                    if (!r_pvalid) begin
                        n_prefix = t_code'(s_axis_tdata);
                        n_pvalid = 1'b1;
                        n_state  = ST_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = key;
                        n_addr  = key;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (rd_data.valid && rd_data.pfx == r_prefix && rd_data.byt == r_byte) begin
                    n_prefix = rd_data.code;
                    n_state  = ST_FIN;
                end else if (rd_data.valid) begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                    n_addr  = r_addr + 1'b1;
                end else begin
                    push      = 1'b1;
                    push_data = '{last: 1'b0, width: r_width, code: r_prefix};
                    if (!r_nfc[MAX_CODE_BITS]) begin
                        wr_en   = 1'b1;
                        wr_data = '{valid: 1'b1, pfx: r_prefix, byt: r_byte,
                                    code: r_nfc[MAX_CODE_BITS-1:0]};
                        n_nfc   = nfc_inc;
                        if (r_width < t_width'(MAX_CODE_BITS) &&
                            nfc_inc >= (t_next_code'(1) << r_width)) begin
                            n_width = r_width + 1'b1;
                        end
                    end
                    n_prefix = t_code'(r_byte);
                    n_state  = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_end) begin
                    push      = 1'b1;
                    push_data = '{last: 1'b1, width: r_width, code: r_prefix};
                    n_prefix  = '0;
                    n_pvalid  = 1'b0;
                    n_nfc     = t_next_code'(FIRST_FREE_CODE);
                    n_width   = t_width'(START_WIDTH);
                    n_clr     = '0;
                    n_state   = ST_CLEAR;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_prefix <= '0;
            r_pvalid <= 1'b0;
            r_nfc    <= t_next_code'(FIRST_FREE_CODE);
            r_width  <= t_width'(START_WIDTH);
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_pvalid <= n_pvalid;
            r_nfc    <= n_nfc;
            r_width  <= n_width;
            r_clr    <= n_clr;
        end
        r_byte <= n_byte;
        r_end  <= n_end;
        r_addr <= n_addr;
    end

endmodule

`default_nettype wire
